// ===== rtl/kpsd_pkg.sv =====
// Package for the keypad scanner: word layouts, phase codes, widths
// and the key code table. No dependencies.
package kpsd_pkg;

    localparam int TICK_COUNT_WIDTH = 8;
    localparam int CFG_WIDTH        = 8;
    localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > CFG_WIDTH) ?
                                      TICK_COUNT_WIDTH : CFG_WIDTH;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_PRESS   = 2'd1;
    localparam logic [1:0] PHASE_HELD    = 2'd2;
    localparam logic [1:0] PHASE_RELEASE = 2'd3;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0]     COLS_IDLE     = 3'b111;
    localparam logic [3:0]     ROWS_IDLE     = 4'hF;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 8'd4;

    typedef struct packed {
        logic       op;
        logic [2:0] columns;
    } t_in_word;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic [1:0] phase;
    } t_out_word;

    // ASCII code of the key at a given row and column.
    function automatic logic [7:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        code = 8'h00;
        unique case ({row, col})
            4'b00_00: code = "1";
            4'b00_01: code = "2";
            4'b00_10: code = "3";
            4'b01_00: code = "4";
            4'b01_01: code = "5";
            4'b01_10: code = "6";
            4'b10_00: code = "7";
            4'b10_01: code = "8";
            4'b10_10: code = "9";
            4'b11_00: code = "*";
            4'b11_01: code = "0";
            4'b11_10: code = "#";
            default:  code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/keypad_scan_debounce.sv =====
// Top level of the 4x3 keypad scanner with press and release debounce.
// Depends on kpsd_pkg for word types, phase codes and the key table.
//
//  Channel   Direction  Handshake                      Word
//  ------------------------------------------------------------------------
//  input     in         i_in_valid / o_in_stall        t_in_word (op, columns)
//  output    out        o_out_valid / i_out_stall      t_out_word (row_drive,
//                                                      key_valid, key_code, phase)
//  config    in         i_cfg_we / i_cfg_data          debounce_ticks, 8 bits
//
// Every accepted word produces exactly one result word, and a word can be
// accepted on every clock while the skid register is empty. The state update
// and the result are computed in the cycle of acceptance, then registered.
// The output register is backed by a one-entry skid register, so a stalled
// output only stops input acceptance once the skid register is occupied.
// Reset is synchronous and active low; it clears the scan state, the tick
// counter, the debounce register (to 4) and both valid flags.
module keypad_scan_debounce
    import kpsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_word             i_in_word,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_word            o_out_word,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

    // Scanner state.
    logic [1:0]                  r_phase, n_phase;
    logic [1:0]                  r_scan_row, n_scan_row;
    logic [TICK_COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]                  r_rows, n_rows;
    logic [CFG_WIDTH-1:0]        r_debounce;

    // Output register and skid register.
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;
    logic      r_skid_valid, n_skid_valid;
    t_out_word r_skid_word, n_skid_word;

    logic      in_accept;
    logic      out_take;
    logic      wait_done;
    logic      hit;
    logic [1:0] hit_col;
    t_out_word result;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_out_stall;

    // A wait ends once the tick count has reached the configured count.
    assign wait_done = CMP_WIDTH'(r_tick) >= CMP_WIDTH'(r_debounce);

    // The first low column wins, column 0 first.
    always_comb begin
        hit     = 1'b1;
        hit_col = 2'd0;
        if (!i_in_word.columns[0]) begin
            hit_col = 2'd0;
        end else if (!i_in_word.columns[1]) begin
            hit_col = 2'd1;
        end else if (!i_in_word.columns[2]) begin
            hit_col = 2'd2;
        end else begin
            hit = 1'b0;
        end
    end

    // Next state and the result word of the item being accepted.
    always_comb begin
        n_phase    = r_phase;
        n_scan_row = r_scan_row;
        n_tick     = r_tick;
        n_rows     = r_rows;
        result.key_valid = 1'b0;
        result.key_code  = 8'h00;

        if (i_in_word.op == OP_TICK) begin
            // Ticks only advance the saturating counter.
            if (r_tick != TICK_MAX) begin
                n_tick = r_tick + 1'b1;
            end
        end else begin
            unique case (r_phase)
                PHASE_IDLE: begin
                    // Drive the current row low; the columns of this poll are
                    // read under that drive.
                    n_rows     = ROWS_IDLE & ~(4'b0001 << r_scan_row);
                    n_scan_row = r_scan_row + 2'd1;
                    if (hit) begin
                        result.key_valid = 1'b1;
                        result.key_code  = key_ascii(r_scan_row, hit_col);
                        n_tick           = '0;
                        n_phase          = PHASE_PRESS;
                    end
                end
                PHASE_PRESS: begin
                    if (wait_done) begin
                        n_phase = PHASE_HELD;
                    end
                end
                PHASE_HELD: begin
                    // The last driven row stays on; all columns high means
                    // the key was let go.
                    if (i_in_word.columns == COLS_IDLE) begin
                        n_tick  = '0;
                        n_phase = PHASE_RELEASE;
                    end
                end
                PHASE_RELEASE: begin
                    if (wait_done) begin
                        n_phase = PHASE_IDLE;
                    end
                end
                default: begin
                    n_phase = PHASE_IDLE;
                end
            endcase
        end

        result.row_drive = n_rows;
        result.phase     = n_phase;
    end

    // Output register with a skid entry behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out_valid = 1'b1;
                n_out_word  = result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            n_skid_valid = 1'b1;
            n_skid_word  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_IDLE;
            r_scan_row   <= 2'd0;
            r_tick       <= '0;
            r_rows       <= ROWS_IDLE;
            r_debounce   <= DEBOUNCE_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase    <= n_phase;
                r_scan_row <= n_scan_row;
                r_tick     <= n_tick;
                r_rows     <= n_rows;
            end
            if (i_cfg_we) begin
                r_debounce <= i_cfg_data;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
